### hdl/vvt_pkg.sv
// ----------------------------------------------------------------------------
// vvt_pkg
// Shared types and constants for the version vector table: command codes,
// status codes and the transaction token that walks the row of entry cells.
// ----------------------------------------------------------------------------
package vvt_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int WORD_W        = 64;
    localparam int STATUS_W      = 3;

    typedef enum logic [1:0] {
        CMD_MERGE = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_QUERY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

    // Payload of a token as it moves from cell to cell
    typedef struct packed {
        cmd_t              cmd;
        logic [WORD_W-1:0] key_upper;
        logic [WORD_W-1:0] key_lower;
        logic [WORD_W-1:0] low;
        logic [WORD_W-1:0] high;
        logic              last;
        logic [CNT_W-1:0]  count;     // fill count seen when the item entered
        logic              hit;       // a valid entry matched the key
        logic              appended;  // the item was written into a free cell
        logic [WORD_W-1:0] hit_high;  // stored high of the matching entry
    } token_data_t;

    typedef struct packed {
        logic        valid;
        token_data_t data;
    } token_t;

endpackage

### hdl/vvt_in_if.sv
// ----------------------------------------------------------------------------
// vvt_in_if
// Request channel of the version vector table: valid/ready plus item fields.
// ----------------------------------------------------------------------------
interface vvt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] key_upper;
    logic [63:0] key_lower;
    logic [63:0] range_low;
    logic [63:0] range_high;
    logic        last_of_vector;

    modport source (
        output valid, command, key_upper, key_lower, range_low, range_high,
               last_of_vector,
        input  ready
    );

    modport sink (
        input  valid, command, key_upper, key_lower, range_low, range_high,
               last_of_vector,
        output ready
    );
endinterface

### hdl/vvt_out_if.sv
// ----------------------------------------------------------------------------
// vvt_out_if
// Result channel of the version vector table: valid/ready plus result fields.
// ----------------------------------------------------------------------------
interface vvt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        emit;
    logic [63:0] out_key_upper;
    logic [63:0] out_key_lower;
    logic [63:0] out_low;
    logic [63:0] out_high;
    logic        out_last;

    modport source (
        output valid, status, emit, out_key_upper, out_key_lower, out_low,
               out_high, out_last,
        input  ready
    );

    modport sink (
        input  valid, status, emit, out_key_upper, out_key_lower, out_low,
               out_high, out_last,
        output ready
    );
endinterface

### hdl/vvt_cell.sv
// ----------------------------------------------------------------------------
// vvt_cell
// One table entry. Matches the passing token against its key, merges or
// takes the append, and hands the token, registered, to the next cell.
// ----------------------------------------------------------------------------
module vvt_cell
    import vvt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] idx,
    input  token_t           tok_in,
    output token_t           tok_out
);

    logic [WORD_W-1:0] key_upper_reg;
    logic [WORD_W-1:0] key_lower_reg;
    logic [WORD_W-1:0] low_reg;
    logic [WORD_W-1:0] high_reg;
    logic              tok_valid_reg;
    token_data_t       tok_data_reg;
    token_data_t       tok_data_next;

    logic entry_live;
    logic match;
    logic do_merge;
    logic do_append;

    // Entry is live only below the fill count carried by the token
    assign entry_live = (idx < tok_in.data.count);
    assign match      = tok_in.valid && entry_live && !tok_in.data.hit
                        && (key_upper_reg == tok_in.data.key_upper)
                        && (key_lower_reg == tok_in.data.key_lower);
    assign do_merge   = match && (tok_in.data.cmd == CMD_MERGE);
    assign do_append  = tok_in.valid && (tok_in.data.cmd == CMD_MERGE)
                        && !tok_in.data.hit && (idx == tok_in.data.count);

    always_comb
    begin
        tok_data_next = tok_in.data;
        if (match)
        begin
            tok_data_next.hit      = 1'b1;
            tok_data_next.hit_high = high_reg;
        end
        if (do_append)
        begin
            tok_data_next.appended = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            key_upper_reg <= tok_in.data.key_upper;
            key_lower_reg <= tok_in.data.key_lower;
            low_reg       <= tok_in.data.low;
            high_reg      <= tok_in.data.high;
        end
        else if (do_merge)
        begin
            if (tok_in.data.low < low_reg)
            begin
                low_reg <= tok_in.data.low;
            end
            if (tok_in.data.high > high_reg)
            begin
                high_reg <= tok_in.data.high;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_data_reg <= tok_data_next;
    end

    assign tok_out.valid = tok_valid_reg;
    assign tok_out.data  = tok_data_reg;

endmodule

### hdl/version_vector_table_core.sv
// Flow: an accepted transaction enters the head cell at the accepting edge and
//   walks the TABLE_ENTRIES cells, one per cycle; the result register loads
//   from the token as it leaves the last cell.
// Occupancy: one transaction in flight; the next is taken the cycle after the
//   result is delivered (the unused command forms no result and frees the block
//   when its token leaves the last cell). Reset: clears the fill count and
//   all handshake state; entries keep no reset.
// ----------------------------------------------------------------------------
// version_vector_table_core
// Table of version ranges keyed by 128-bit identifiers. Each entry lives in a
// cell of a row; a transaction token passes down the row, matches its key,
// merges the range in place or appends into the first free cell, and leaves
// the last cell carrying everything needed to form the result.
// ----------------------------------------------------------------------------
module version_vector_table_core
    import vvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    vvt_in_if.sink     req,
    vvt_out_if.source  rsp
);

    token_t tok_chain [0:TABLE_ENTRIES];

    logic             busy_reg;
    logic [CNT_W-1:0] count_reg;
    logic             out_valid_reg;

    logic [STATUS_W-1:0] status_reg;
    logic                emit_reg;
    logic [WORD_W-1:0]   key_upper_reg;
    logic [WORD_W-1:0]   key_lower_reg;
    logic [WORD_W-1:0]   low_reg;
    logic [WORD_W-1:0]   high_reg;
    logic                last_reg;

    logic [STATUS_W-1:0] status_next;
    logic                emit_next;
    logic                req_fire;
    logic                rsp_fire;
    token_t              tail;

    // Take a new transaction only when nothing is in flight or waiting
    assign req.ready = !busy_reg;
    assign req_fire  = req.valid && req.ready;
    assign rsp_fire  = rsp.valid && rsp.ready;

    // Launch the token into the head cell with the current fill count
    always_comb
    begin
        tok_chain[0].valid              = req_fire;
        tok_chain[0].data.cmd           = cmd_t'(req.command);
        tok_chain[0].data.key_upper     = req.key_upper;
        tok_chain[0].data.key_lower     = req.key_lower;
        tok_chain[0].data.low           = req.range_low;
        tok_chain[0].data.high          = req.range_high;
        tok_chain[0].data.last          = req.last_of_vector;
        tok_chain[0].data.count         = count_reg;
        tok_chain[0].data.hit           = 1'b0;
        tok_chain[0].data.appended      = 1'b0;
        tok_chain[0].data.hit_high      = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            vvt_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .idx     (CNT_W'(gi)),
                .tok_in  (tok_chain[gi]),
                .tok_out (tok_chain[gi+1])
            );
        end
    endgenerate

    assign tail = tok_chain[TABLE_ENTRIES];

    // Form status and emit from the token leaving the last cell
    always_comb
    begin
        status_next = ST_CLEARED;
        emit_next   = 1'b0;
        unique case (tail.data.cmd)
            CMD_MERGE:
            begin
                if (tail.data.hit)
                begin
                    status_next = ST_MERGED;
                end
                else if (tail.data.appended)
                begin
                    status_next = ST_APPENDED;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            CMD_QUERY:
            begin
                status_next = ST_QUERY;
                // Unknown key passes as is; a known key emits only if behind
                emit_next   = !tail.data.hit || (tail.data.hit_high < tail.data.high);
            end
            CMD_CLEAR:
            begin
                status_next = ST_CLEARED;
            end
            default:
            begin
                status_next = ST_CLEARED;
            end
        endcase
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge clk)
    begin
        if (tail.valid && (tail.data.cmd != CMD_NONE))
        begin
            status_reg    <= status_next;
            emit_reg      <= emit_next;
            key_upper_reg <= emit_next ? tail.data.key_upper : '0;
            key_lower_reg <= emit_next ? tail.data.key_lower : '0;
            low_reg       <= !emit_next ? '0
                             : (tail.data.hit ? tail.data.hit_high : tail.data.low);
            high_reg      <= emit_next ? tail.data.high : '0;
            last_reg      <= tail.data.last;
        end
    end

    // Control: busy flag, result valid and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (req_fire)
            begin
                busy_reg <= 1'b1;
            end
            if (tail.valid)
            begin
                if (tail.data.cmd == CMD_NONE)
                begin
                    // No result for an unused command: free the block now
                    busy_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
                if (tail.data.cmd == CMD_CLEAR)
                begin
                    count_reg <= '0;
                end
                else if (tail.data.appended)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (rsp_fire)
            begin
                out_valid_reg <= 1'b0;
                busy_reg      <= 1'b0;
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.emit          = emit_reg;
    assign rsp.out_key_upper = key_upper_reg;
    assign rsp.out_key_lower = key_lower_reg;
    assign rsp.out_low       = low_reg;
    assign rsp.out_high      = high_reg;
    assign rsp.out_last      = last_reg;

endmodule
